// File: rtl/rrtt_pkg.sv
// Shared constants and types for the round-robin thread slot table.
`default_nettype none

package rrtt_pkg;

   // Table size and field widths.
   localparam int SLOT_COUNT = 64;
   localparam int ID_W       = 6;
   localparam int DATA_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int REQ_W      = 2;

   // Only slots that a 6-bit field can name are kept in the ring.
   localparam int USE_SLOTS = (SLOT_COUNT < (1 << ID_W)) ? SLOT_COUNT : (1 << ID_W);
   localparam int IDX_W     = (USE_SLOTS > 1) ? $clog2(USE_SLOTS) : 1;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_YIELD  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DONE   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_JOIN   = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_WAIT = 2'd2;

   // Per-slot flags held by one ring cell.
   typedef struct packed {
      logic in_use;
      logic finished;
   } slot_bits_type;

endpackage

`default_nettype wire

// File: rtl/rrtt_cell.sv
// One ring cell: holds the flags of one slot and passes them on while the ring turns.
`default_nettype none

module rrtt_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire rrtt_pkg::slot_bits_type init_bits,
   input  wire                    shift_en,
   input  wire rrtt_pkg::slot_bits_type bits_in,
   output rrtt_pkg::slot_bits_type bits_out
);
   import rrtt_pkg::*;

   slot_bits_type bits_ff;
   slot_bits_type bits_in_d;

   // Take the neighbor's flags on every turn of the ring.
   always_comb begin
      bits_in_d = shift_en ? bits_in : bits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= init_bits;
      end else begin
         bits_ff <= bits_in_d;
      end
   end

   assign bits_out = bits_ff;

endmodule

`default_nettype wire

// File: rtl/rrtt_seq.sv
// Sequencer: turns the ring once per item, updates the head slot and builds the result.
`default_nettype none

module rrtt_seq (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire  [rrtt_pkg::REQ_W-1:0]  req_type,
   input  wire  [rrtt_pkg::ID_W-1:0]   req_thread_id,
   input  wire  [rrtt_pkg::ID_W-1:0]   req_caller_id,
   input  wire  [rrtt_pkg::DATA_W-1:0] req_result_value,
   output logic                        shift_en,
   input  wire rrtt_pkg::slot_bits_type head_bits,
   output rrtt_pkg::slot_bits_type     head_new,
   output logic                        rsp_strobe,
   output logic [rrtt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrtt_pkg::ID_W-1:0]   rsp_chosen_slot,
   output logic                        rsp_do_switch,
   output logic [rrtt_pkg::DATA_W-1:0] rsp_joined_result
);
   import rrtt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   // Captured request.
   logic [REQ_W-1:0]  rtype_ff;
   logic [ID_W-1:0]   tid_ff, cid_ff;
   logic [DATA_W-1:0] val_ff;

   // Scan accumulators.
   logic              aft_found_ff, aft_found_in;
   logic [ID_W-1:0]   aft_slot_ff, aft_slot_in;
   logic              wrp_found_ff, wrp_found_in;
   logic [ID_W-1:0]   wrp_slot_ff, wrp_slot_in;
   logic              crt_found_ff, crt_found_in;
   logic [ID_W-1:0]   crt_slot_ff, crt_slot_in;
   logic              tgt_run_ff, tgt_run_in;

   // Result storage with one valid bit per slot; an invalid entry reads as zero.
   logic [DATA_W-1:0] res_mem [USE_SLOTS];
   logic [USE_SLOTS-1:0] res_vld_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // Output registers.
   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_chosen_ff, rsp_chosen_in;
   logic                rsp_switch_ff, rsp_switch_in;
   logic [DATA_W-1:0]   rsp_joined_ff, rsp_joined_in;

   logic            accept;
   logic            last_step;
   logic [ID_W-1:0] cur_id;
   logic [ID_W-1:0] base_id;
   logic            head_run;
   logic            tid_ok, cid_ok;
   logic            pick_found;
   logic [ID_W-1:0] pick_slot;
   logic [IDX_W-1:0] tid_idx;
   logic [IDX_W-1:0] crt_idx;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign shift_en  = (state_ff == S_SCAN);
   assign last_step = (cnt_ff == IDX_W'(USE_SLOTS - 1));
   assign cur_id    = ID_W'(cnt_ff);
   assign base_id   = (rtype_ff == REQ_JOIN) ? cid_ff : tid_ff;
   assign head_run  = head_bits.in_use && !head_bits.finished;
   assign tid_ok    = (32'(tid_ff) < SLOT_COUNT);
   assign cid_ok    = (32'(cid_ff) < SLOT_COUNT);
   assign tid_idx   = tid_ff[IDX_W-1:0];
   assign crt_idx   = crt_slot_ff[IDX_W-1:0];

   // Sequence control: one full turn of the ring, then a finishing state to form the result.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (last_step) begin
               cnt_in   = '0;
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Head slot update and scan bookkeeping while the ring turns.
   always_comb begin
      head_new     = head_bits;
      aft_found_in = aft_found_ff;
      aft_slot_in  = aft_slot_ff;
      wrp_found_in = wrp_found_ff;
      wrp_slot_in  = wrp_slot_ff;
      crt_found_in = crt_found_ff;
      crt_slot_in  = crt_slot_ff;
      tgt_run_in   = tgt_run_ff;
      if (accept) begin
         aft_found_in = 1'b0;
         wrp_found_in = 1'b0;
         crt_found_in = 1'b0;
         crt_slot_in  = '0;
         tgt_run_in   = 1'b0;
      end else if (state_ff == S_SCAN) begin
         // Runnable slots after the base, and before it for the wrap-around case.
         if (head_run && (cur_id > base_id) && !aft_found_ff) begin
            aft_found_in = 1'b1;
            aft_slot_in  = cur_id;
         end
         if (head_run && (cur_id < base_id) && !wrp_found_ff) begin
            wrp_found_in = 1'b1;
            wrp_slot_in  = cur_id;
         end
         if (cur_id == tid_ff) begin
            tgt_run_in = head_run;
         end
         case (rtype_ff)
            REQ_CREATE: begin
               // Claim the lowest free slot above the main thread.
               if ((cur_id != '0) && !head_bits.in_use && !crt_found_ff) begin
                  head_new.in_use   = 1'b1;
                  head_new.finished = 1'b0;
                  crt_found_in      = 1'b1;
                  crt_slot_in       = cur_id;
               end
            end
            REQ_DONE: begin
               if (cur_id == tid_ff) begin
                  head_new.finished = 1'b1;
               end
            end
            REQ_JOIN: begin
               // A finished target is freed by the join.
               if ((cur_id == tid_ff) && head_bits.in_use && head_bits.finished) begin
                  head_new.in_use = 1'b0;
               end
            end
            default: begin
               head_new = head_bits;
            end
         endcase
      end
   end

   assign pick_found = aft_found_ff || wrp_found_ff;
   assign pick_slot  = aft_found_ff ? aft_slot_ff : wrp_slot_ff;

   // Result formation from the accumulated scan.
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_chosen_in = '0;
      rsp_switch_in = 1'b0;
      rsp_joined_in = '0;
      case (rtype_ff)
         REQ_CREATE: begin
            rsp_status_in = crt_found_ff ? ST_OK : ST_FULL;
            rsp_chosen_in = crt_slot_ff;
         end
         REQ_YIELD: begin
            if (tid_ok && pick_found) begin
               rsp_chosen_in = pick_slot;
               rsp_switch_in = 1'b1;
            end else begin
               rsp_chosen_in = tid_ff;
            end
         end
         REQ_DONE: begin
            if (tid_ok) begin
               rsp_switch_in = (tid_ff != '0);
            end else begin
               rsp_chosen_in = tid_ff;
            end
         end
         REQ_JOIN: begin
            if (tgt_run_ff) begin
               rsp_status_in = ST_WAIT;
               if (cid_ok && pick_found) begin
                  rsp_chosen_in = pick_slot;
                  rsp_switch_in = 1'b1;
               end else begin
                  rsp_chosen_in = cid_ff;
               end
            end else begin
               rsp_chosen_in = cid_ff;
               if (tid_ok && res_vld_ff[tid_idx]) begin
                  rsp_joined_in = rd_data_ff;
               end
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         aft_found_ff  <= 1'b0;
         wrp_found_ff  <= 1'b0;
         crt_found_ff  <= 1'b0;
         tgt_run_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= (state_ff == S_FINISH);
         aft_found_ff  <= aft_found_in;
         wrp_found_ff  <= wrp_found_in;
         crt_found_ff  <= crt_found_in;
         tgt_run_ff    <= tgt_run_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         rtype_ff <= req_type;
         tid_ff   <= req_thread_id;
         cid_ff   <= req_caller_id;
         val_ff   <= req_result_value;
      end
      aft_slot_ff <= aft_slot_in;
      wrp_slot_ff <= wrp_slot_in;
      crt_slot_ff <= crt_slot_in;
      if (state_ff == S_FINISH) begin
         rsp_status_ff <= rsp_status_in;
         rsp_chosen_ff <= rsp_chosen_in;
         rsp_switch_ff <= rsp_switch_in;
         rsp_joined_ff <= rsp_joined_in;
      end
   end

   // Result memory: written when a done item finishes, read during the scan.
   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && (rtype_ff == REQ_DONE) && tid_ok) begin
         res_mem[tid_idx] <= val_ff;
      end
      rd_data_ff <= res_mem[tid_idx];
   end

   // Valid bits: set by done, cleared by create so a new slot reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= '0;
      end else if (state_ff == S_FINISH) begin
         if ((rtype_ff == REQ_DONE) && tid_ok) begin
            res_vld_ff[tid_idx] <= 1'b1;
         end else if ((rtype_ff == REQ_CREATE) && crt_found_ff) begin
            res_vld_ff[crt_idx] <= 1'b0;
         end
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_slot   = rsp_chosen_ff;
   assign rsp_do_switch     = rsp_switch_ff;
   assign rsp_joined_result = rsp_joined_ff;

   // A result strobe lasts one cycle and follows the finishing cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_FINISH))
      else $error("result strobe without a finishing cycle");

   // The ring is back at its home position whenever the block is idle.
   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cnt_ff == '0))
      else $error("ring position lost while idle");

   // An accepted item starts a scan.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN))
      else $error("accepted item did not start a scan");

endmodule

`default_nettype wire

// File: rtl/round_robin_thread_table_top.sv
// Top level of the round-robin thread slot table: a ring of slot cells and its sequencer.
//
// Usage: drive req_type, req_thread_id, req_caller_id and req_result_value and raise
// start; the item is taken at the rising edge where start is high and busy is low.
// Request codes are create, yield, thread done and join. The result appears on the
// rsp_ ports for exactly one cycle, marked by rsp_strobe; the receiver cannot stall it,
// so it must take the result in that cycle.
// Each item turns the ring of slot cells once, one slot per cycle past the head cell,
// where the sequencer reads and updates that slot; the ring length of 64 cells sets the
// timing. After the scan a finishing state forms the result and the result strobe rises
// from the register behind it; busy falls in the strobe cycle, so the next item can be
// taken at the edge at which the result is taken, but not while an item is in progress.
// Result words live in a 64-entry memory inside the sequencer, read at the requested slot.
// Reset (synchronous, active high) marks slot 0 in use, all other slots free, no slot
// finished and every stored result as zero; no clearing pass is needed.
`default_nettype none

module round_robin_thread_table_top (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [rrtt_pkg::REQ_W-1:0]    req_type,
   input  wire  [rrtt_pkg::ID_W-1:0]     req_thread_id,
   input  wire  [rrtt_pkg::ID_W-1:0]     req_caller_id,
   input  wire  [rrtt_pkg::DATA_W-1:0]   req_result_value,
   output logic                          rsp_strobe,
   output logic [rrtt_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrtt_pkg::ID_W-1:0]     rsp_chosen_slot,
   output logic                          rsp_do_switch,
   output logic [rrtt_pkg::DATA_W-1:0]   rsp_joined_result
);
   import rrtt_pkg::*;

   slot_bits_type cell_out [USE_SLOTS];
   slot_bits_type head_new;
   logic          shift_en;

   // Ring of slot cells; the head cell is cell 0 and its update re-enters at the tail.
   for (genvar i = 0; i < USE_SLOTS; i++) begin : g_cell
      slot_bits_type init_bits;
      slot_bits_type bits_in;

      assign init_bits.in_use   = (i == 0);
      assign init_bits.finished = 1'b0;

      if (i == USE_SLOTS - 1) begin : g_tail
         assign bits_in = head_new;
      end else begin : g_link
         assign bits_in = cell_out[i + 1];
      end

      rrtt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .init_bits (init_bits),
         .shift_en  (shift_en),
         .bits_in   (bits_in),
         .bits_out  (cell_out[i])
      );
   end

   // Sequencer, result memory and output registers.
   rrtt_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_thread_id     (req_thread_id),
      .req_caller_id     (req_caller_id),
      .req_result_value  (req_result_value),
      .shift_en          (shift_en),
      .head_bits         (cell_out[0]),
      .head_new          (head_new),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_chosen_slot   (rsp_chosen_slot),
      .rsp_do_switch     (rsp_do_switch),
      .rsp_joined_result (rsp_joined_result)
   );

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the round-robin thread slot table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rrtt_pkg::*;

   // Run length guard and the quiet time allowed after the last reply.
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 70;
   localparam int REPORT_LIMIT  = 10;

   // Stimulus shaping: phases that fill, churn and drain the table.
   localparam int PHASE_COUNT     = 12;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int MODE_FILL       = 0;
   localparam int MODE_CHURN      = 1;
   localparam int MODE_DRAIN      = 2;

   // Slot classes used when picking ids for well-formed requests.
   localparam int PICK_RUNNABLE = 0;
   localparam int PICK_FINISHED = 1;

   // One reply item as seen on the rsp_ ports.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     chosen;
      logic                do_switch;
      logic [DATA_W-1:0]   joined;
   } slot_reply_type;

   // Scoreboard: holds a private copy of the slot table and the replies still owed.
   class slot_table_scoreboard;
      bit                in_use   [SLOT_COUNT];
      bit                finished [SLOT_COUNT];
      logic [DATA_W-1:0] stored   [SLOT_COUNT];
      slot_reply_type    owed_replies [$];
      int                mismatches;
      int                failures;

      function new();
         foreach (in_use[s]) begin
            in_use[s]   = 1'b0;
            finished[s] = 1'b0;
            stored[s]   = '0;
         end
         in_use[0]  = 1'b1;
         mismatches = 0;
         failures   = 0;
      endfunction

      function bit runnable(int s);
         return s < SLOT_COUNT && in_use[s] && !finished[s];
      endfunction

      // Circular search for the first runnable slot after the given one.
      function bit find_runnable_after(int from, output logic [ID_W-1:0] pick);
         int s;
         pick = '0;
         if (from >= SLOT_COUNT) return 1'b0;
         for (int k = 1; k < USE_SLOTS; k++) begin
            s = (from + k) % USE_SLOTS;
            if (runnable(s)) begin
               pick = ID_W'(s);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Computes the reply for one request and applies its effect on the table.
      function slot_reply_type predict_reply(logic [REQ_W-1:0] kind, logic [ID_W-1:0] tid,
                                             logic [ID_W-1:0] cid, logic [DATA_W-1:0] word);
         slot_reply_type  r;
         logic [ID_W-1:0] pick;
         bit              found;
         r     = '0;
         found = 1'b0;
         case (kind)
            REQ_CREATE: begin
               for (int s = 1; s < USE_SLOTS; s++) begin
                  if (!found && !in_use[s]) begin
                     in_use[s]   = 1'b1;
                     finished[s] = 1'b0;
                     stored[s]   = '0;
                     r.chosen    = ID_W'(s);
                     found       = 1'b1;
                  end
               end
               if (!found) r.status = ST_FULL;
            end
            REQ_YIELD: begin
               if (find_runnable_after(int'(tid), pick)) begin
                  r.chosen    = pick;
                  r.do_switch = 1'b1;
               end else begin
                  r.chosen = tid;
               end
            end
            REQ_DONE: begin
               if (int'(tid) < SLOT_COUNT) begin
                  finished[tid] = 1'b1;
                  stored[tid]   = word;
                  r.do_switch   = (tid != '0);
               end else begin
                  r.chosen = tid;
               end
            end
            default: begin
               // A join either waits on a running target or collects its result.
               if (runnable(int'(tid))) begin
                  r.status = ST_WAIT;
                  if (find_runnable_after(int'(cid), pick)) begin
                     r.chosen    = pick;
                     r.do_switch = 1'b1;
                  end else begin
                     r.chosen = cid;
                  end
               end else begin
                  r.chosen = cid;
                  if (int'(tid) < SLOT_COUNT) begin
                     r.joined = stored[tid];
                     if (in_use[tid] && finished[tid]) in_use[tid] = 1'b0;
                  end
               end
            end
         endcase
         return r;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] tid,
                                 logic [ID_W-1:0] cid, logic [DATA_W-1:0] word);
         owed_replies.push_back(predict_reply(kind, tid, cid, word));
      endfunction

      // Compares one reply with the oldest one owed.
      function void check_reply(slot_reply_type got);
         slot_reply_type want;
         if (owed_replies.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected reply: status %0d slot %0d switch %0d result %h",
                        got.status, got.chosen, got.do_switch, got.joined);
            return;
         end
         want = owed_replies.pop_front();
         if (got.status !== want.status || got.chosen !== want.chosen ||
             got.do_switch !== want.do_switch || got.joined !== want.joined) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("reply mismatch at %0t: status %0d/%0d slot %0d/%0d switch %0d/%0d",
                        $realtime, want.status, got.status, want.chosen, got.chosen,
                        want.do_switch, got.do_switch);
               $display("   result %h/%h", want.joined, got.joined);
            end
         end
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [REQ_W-1:0]    req_type;
   logic [ID_W-1:0]     req_thread_id;
   logic [ID_W-1:0]     req_caller_id;
   logic [DATA_W-1:0]   req_result_value;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_chosen_slot;
   logic                rsp_do_switch;
   logic [DATA_W-1:0]   rsp_joined_result;

   slot_table_scoreboard sb = new();
   int                   cycle_count = 0;

   round_robin_thread_table_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_thread_id     (req_thread_id),
      .req_caller_id     (req_caller_id),
      .req_result_value  (req_result_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_chosen_slot   (rsp_chosen_slot),
      .rsp_do_switch     (rsp_do_switch),
      .rsp_joined_result (rsp_joined_result)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every reply item is taken in its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_reply({rsp_status, rsp_chosen_slot, rsp_do_switch, rsp_joined_result});
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** round_robin_thread_table_top: FAILED **");
         $finish;
      end
   end

   // Presents one request item and holds it until the block takes it.
   task automatic send_item(logic [REQ_W-1:0] kind, logic [ID_W-1:0] tid,
                            logic [ID_W-1:0] cid, logic [DATA_W-1:0] word);
      @(negedge clock);
      start            <= 1'b1;
      req_type         <= kind;
      req_thread_id    <= tid;
      req_caller_id    <= cid;
      req_result_value <= word;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(kind, tid, cid, word);
   endtask

   // Idle cycles with start low and junk on the request fields.
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start            <= 1'b0;
         req_type         <= REQ_W'($urandom);
         req_thread_id    <= ID_W'($urandom);
         req_caller_id    <= ID_W'($urandom);
         req_result_value <= {$urandom, $urandom};
      end
   endtask

   // Holds the sender off until every owed reply has arrived.
   task automatic wait_for_replies();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Picks a slot of the requested class from the predicted table, else any slot.
   function automatic logic [ID_W-1:0] pick_slot(int kind);
      int candidates [$];
      for (int s = 0; s < USE_SLOTS; s++) begin
         if (kind == PICK_RUNNABLE && sb.runnable(s)) candidates.push_back(s);
         if (kind == PICK_FINISHED && sb.in_use[s] && sb.finished[s]) candidates.push_back(s);
      end
      if (candidates.size() == 0) return ID_W'($urandom);
      return ID_W'(candidates[$urandom_range(0, candidates.size() - 1)]);
   endfunction

   // One random request item, weighted by the phase mode.
   task automatic random_item(int mode);
      int              r;
      int              create_cut;
      int              yield_cut;
      int              done_cut;
      logic [ID_W-1:0] tid;
      logic [ID_W-1:0] cid;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            create_cut = 55; yield_cut = 75; done_cut = 88;
         end
         MODE_CHURN: begin
            create_cut = 20; yield_cut = 50; done_cut = 75;
         end
         default: begin
            create_cut = 5; yield_cut = 30; done_cut = 60;
         end
      endcase
      cid = ($urandom_range(0, 9) < 7) ? pick_slot(PICK_RUNNABLE) : ID_W'($urandom);
      if (r < create_cut) begin
         send_item(REQ_CREATE, ID_W'($urandom), cid, random_word());
      end else if (r < yield_cut) begin
         tid = ($urandom_range(0, 3) != 0) ? pick_slot(PICK_RUNNABLE) : ID_W'($urandom);
         send_item(REQ_YIELD, tid, cid, random_word());
      end else if (r < done_cut) begin
         tid = ($urandom_range(0, 4) != 0) ? pick_slot(PICK_RUNNABLE) : ID_W'($urandom);
         send_item(REQ_DONE, tid, cid, random_word());
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) tid = pick_slot(PICK_FINISHED);
         else if (r < 75) tid = pick_slot(PICK_RUNNABLE);
         else tid = ID_W'($urandom);
         send_item(REQ_JOIN, tid, cid, random_word());
      end
   endtask

   // Main sequence: reset, directed items, random phases, closing slot 0 items.
   initial begin
      int sent;
      int burst;
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_CREATE;
      req_thread_id    = '0;
      req_caller_id    = '0;
      req_result_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: creates, wrap-around yields, waits, joins of finished,
      // free and stale slots, done on a free slot, and nothing left to run.
      send_item(REQ_CREATE, 6'd0, 6'd0, '0);
      send_item(REQ_CREATE, 6'd63, 6'd63, '1);
      send_item(REQ_CREATE, 6'd0, 6'd0, '0);
      send_item(REQ_YIELD, 6'd0, 6'd0, '0);
      send_item(REQ_YIELD, 6'd3, 6'd0, '0);
      send_item(REQ_JOIN, 6'd2, 6'd0, '0);
      send_item(REQ_DONE, 6'd1, 6'd0, '1);
      send_item(REQ_YIELD, 6'd0, 6'd63, '0);
      send_item(REQ_JOIN, 6'd1, 6'd0, '0);
      send_item(REQ_JOIN, 6'd1, 6'd63, '0);
      send_item(REQ_CREATE, 6'd0, 6'd0, '1);
      send_item(REQ_JOIN, 6'd1, 6'd63, '0);
      send_item(REQ_DONE, 6'd63, 6'd0, 64'h0123_4567_89ab_cdef);
      send_item(REQ_JOIN, 6'd63, 6'd5, '0);
      send_item(REQ_YIELD, 6'd63, 6'd0, '0);
      send_item(REQ_DONE, 6'd2, 6'd0, '0);
      send_item(REQ_DONE, 6'd3, 6'd0, 64'hfedc_ba98_7654_3210);
      send_item(REQ_JOIN, 6'd2, 6'd63, '0);
      send_item(REQ_JOIN, 6'd3, 6'd0, '0);
      send_item(REQ_DONE, 6'd1, 6'd0, 64'h8000_0000_0000_0001);
      send_item(REQ_YIELD, 6'd0, 6'd0, '0);
      send_item(REQ_YIELD, 6'd5, 6'd0, '0);
      send_item(REQ_JOIN, 6'd1, 6'd0, '0);
      wait_for_replies();

      // Random part in bursts; each phase ends with a full drain.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               random_item(phase % 3);
               sent++;
            end
            case ($urandom_range(0, 3))
               0:       ;
               1:       idle_cycles($urandom_range(1, 5));
               2:       idle_cycles($urandom_range(6, 70));
               default: idle_cycles($urandom_range(70, 140));
            endcase
         end
         wait_for_replies();
      end

      // Closing items on the main slot: done with no switch, then a join frees it.
      send_item(REQ_DONE, 6'd0, 6'd0, random_word());
      send_item(REQ_YIELD, 6'd0, 6'd0, '0);
      send_item(REQ_JOIN, 6'd0, 6'd0, '0);
      send_item(REQ_YIELD, 6'd63, 6'd0, '0);

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0d replies never arrived", sb.outstanding());
         sb.failures++;
      end
      if (sb.failures == 0) begin
         $display("** round_robin_thread_table_top: PASSED **");
      end else begin
         $display("** round_robin_thread_table_top: FAILED **");
      end
      $finish;
   end
endmodule
